// ----- src/cmpc_pkg.sv -----
// shared types, codes and constants of the cascaded motor pi controller
package cmpc_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 31;

	localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SUPPLY_VOLTAGE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_GAIN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_INT_TIME   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_LIMIT  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_RAMP   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_GAIN     = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT    = 3'd7;

	// control modes
	localparam logic [1:0] MODE_VOLTAGE  = 2'd0;
	localparam logic [1:0] MODE_ANGLE    = 2'd1;
	localparam logic [1:0] MODE_VELOCITY = 2'd2;

	// register widths
	localparam int VOLT_REG_W = 22;
	localparam int GAIN_REG_W = 31;

	// register reset values
	localparam logic [1:0]            RST_CONTROL_MODE   = MODE_VELOCITY;
	localparam logic [VOLT_REG_W-1:0] RST_SUPPLY_VOLTAGE = 22'd786432;
	localparam logic [GAIN_REG_W-1:0] RST_VELOCITY_GAIN  = 31'd32768;
	localparam logic [GAIN_REG_W-1:0] RST_INV_INT_TIME   = 31'd6553600;
	localparam logic [VOLT_REG_W-1:0] RST_VOLTAGE_LIMIT  = 22'd393216;
	localparam logic [GAIN_REG_W-1:0] RST_VOLTAGE_RAMP   = 31'd6553600;
	localparam logic [GAIN_REG_W-1:0] RST_ANGLE_GAIN     = 31'd65536;
	localparam logic [GAIN_REG_W-1:0] RST_SPEED_LIMIT    = 31'd327680;

	// pwm scale
	localparam int unsigned PWM_FULL_SCALE_DEF = 255;
	localparam int          FS_W               = 16;
	localparam logic [7:0]  PWM_DUTY_MAX       = 8'd255;

	// sample time handling, in microseconds
	localparam int          TS_IN_W       = 24;
	localparam int          TS_W          = 19;
	localparam logic [TS_IN_W-1:0] TS_MAX_US     = 24'd500000;
	localparam logic [TS_W-1:0]    TS_DEFAULT_US = 19'd1000;

	// shared multiplier
	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;

	// shared divider: unsigned, two quotient bits per cycle
	localparam int DIV_DVD_W = 50;
	localparam int DIV_DVS_W = 22;
	localparam int DIV_BITS_PER_CYCLE = 2;

	localparam logic [DIV_DVS_W-1:0] TMP_DIVISOR  = 22'd2000000;
	localparam logic [DIV_DVS_W-1:0] STEP_DIVISOR = 22'd1000000;

	// width of floor(Ts / (2 Ti)) in q16.16, bounded by the largest sample time
	localparam int TMP_W  = 29;
	localparam int STEP_W = 31;

	typedef struct packed {
		logic                        en;
		logic signed [MUL_W-1:0]     a;
		logic signed [MUL_W-1:0]     b;
	} mul_req_t;

	typedef struct packed {
		logic                        start;
		logic [DIV_DVD_W-1:0]        dividend;
		logic [DIV_DVS_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                        done;
		logic [DIV_DVD_W-1:0]        quotient;
	} div_rsp_t;

endpackage

// ----- src/cascaded_motor_pi_controller_core.sv -----
// cascaded position p / velocity pi motor controller, top level
//
// one input transfer is one control tick: target, measured angle and velocity,
// and the microseconds since the previous tick. one output transfer follows
// per tick: drive voltage (q16.16), pwm magnitude and direction.
// registers are written through cfg_write / cfg_index / cfg_data, one per
// cycle. the user must write them only while no tick is in flight; the
// block itself does not enforce it. a small sequencer runs each tick through
// one shared 33x33 multiplier and one shared divider that retires two
// quotient bits per cycle. the quotients each mode needs before out_valid:
//   voltage mode  one quotient, for the pwm scale
//   velocity mode three quotients: Ts/2Ti, slew step, pwm
//   angle mode    the velocity quotients, after the position p step
// a zero supply skips the pwm quotient. in_ready is high only while idle and
// returns with out_valid.
// the result sits in an output register, so the next input transfer is taken
// while a result waits; a stalled receiver holds the block at the end of the
// following tick until the output register is free.
// reset loads the register defaults and clears the pi history (previous
// voltage and previous error) and all control state.
module cascaded_motor_pi_controller_core #(
	parameter int unsigned PWM_FULL_SCALE = cmpc_pkg::PWM_FULL_SCALE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [cmpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cmpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [31:0]                  target,
	input  logic signed [31:0]                  measured_angle,
	input  logic signed [31:0]                  measured_velocity,
	input  logic [cmpc_pkg::TS_IN_W-1:0]        elapsed_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  drive_voltage,
	output logic [7:0]                          pwm_duty,
	output logic                                direction
);

	localparam int FS_W = cmpc_pkg::FS_W;
	localparam logic [FS_W-1:0] FS = FS_W'(PWM_FULL_SCALE);
	localparam int VW = cmpc_pkg::VOLT_REG_W;
	localparam int GW = cmpc_pkg::GAIN_REG_W;
	localparam int MW = cmpc_pkg::MUL_W;
	localparam int PW = cmpc_pkg::PROD_W;
	localparam int DW = cmpc_pkg::DIV_DVD_W;
	localparam logic signed [MW-1:0] ONE_Q16 = 33'sd65536;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANG_MUL,
		ST_ANG_CLAMP,
		ST_ERR,
		ST_TMP_DIV,
		ST_TMP_WAIT,
		ST_ACC_A,
		ST_ACC_B,
		ST_ACC_SUM,
		ST_INNER,
		ST_GAIN_MUL,
		ST_V_SUM,
		ST_V_CLAMP,
		ST_DIFF,
		ST_STEP_WAIT,
		ST_CMP,
		ST_COMMIT,
		ST_PWM_MUL,
		ST_PWM_DIV,
		ST_PWM_WAIT,
		ST_OUT
	} state_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		logic signed [31:0] r;
		if (x > 50'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	state_t state_q;

	// configuration registers
	logic [1:0]    mode_q;
	logic [VW-1:0] supply_q;
	logic [GW-1:0] vgain_q;
	logic [GW-1:0] iit_q;
	logic [VW-1:0] vlimit_q;
	logic [GW-1:0] ramp_q;
	logic [GW-1:0] again_q;
	logic [GW-1:0] spdlim_q;

	// pi history
	logic signed [31:0] prev_v_q;
	logic signed [31:0] prev_e_q;

	// working registers of one tick
	logic signed [31:0]                 tgt_q;
	logic signed [31:0]                 ang_q;
	logic signed [31:0]                 vel_q;
	logic [cmpc_pkg::TS_W-1:0]          ts_q;
	logic signed [31:0]                 err_q;
	logic [cmpc_pkg::TMP_W-1:0]         tmp_q;
	logic signed [63:0]                 acc_q;
	logic signed [31:0]                 inner_q;
	logic signed [49:0]                 v_q;
	logic signed [33:0]                 d_q;
	logic [cmpc_pkg::STEP_W-1:0]        step_q;
	logic                               over_q;
	logic signed [31:0]                 volt_q;
	logic [FS_W-1:0]                    qmag_q;

	// output register
	logic                               out_valid_q;
	logic signed [31:0]                 drive_voltage_q;
	logic [7:0]                         pwm_duty_q;
	logic                               direction_q;

	// shared units
	cmpc_pkg::mul_req_t                 mul_req;
	logic signed [PW-1:0]               prod_q;
	cmpc_pkg::div_req_t                 div_req;
	cmpc_pkg::div_rsp_t                 div_rsp;

	// combinational datapath pieces
	logic [cmpc_pkg::TS_W-1:0]          ts_in;
	logic signed [32:0]                 ang_diff;
	logic signed [31:0]                 ang_err;
	logic signed [32:0]                 err_diff;
	logic signed [49:0]                 ang_sh;
	logic signed [49:0]                 spd_lim;
	logic signed [49:0]                 spd_lim_neg;
	logic signed [MW-1:0]               tmp_ext;
	logic signed [47:0]                 acc_sh;
	logic signed [49:0]                 gain_sh;
	logic [VW-1:0]                      v_lim;
	logic signed [49:0]                 v_lim50;
	logic [33:0]                        d_abs;
	logic signed [33:0]                 prev34;
	logic signed [33:0]                 step34;
	logic signed [33:0]                 v_new;
	logic signed [31:0]                 v_sat;
	logic signed [PW-1:0]               prod_neg;
	logic [DW-1:0]                      pwm_mag;
	logic                               supply_zero;

	cmpc_multiplier u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	cmpc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// long gaps since the last tick fall back to a nominal 1 ms
	assign ts_in = (elapsed_us > cmpc_pkg::TS_MAX_US) ? cmpc_pkg::TS_DEFAULT_US
	                                                  : elapsed_us[cmpc_pkg::TS_W-1:0];

	assign ang_diff = {tgt_q[31], tgt_q} - {ang_q[31], ang_q};
	assign ang_err  = sat32(50'(ang_diff));
	assign err_diff = {tgt_q[31], tgt_q} - {vel_q[31], vel_q};

	// position p output, floor of product >> 16, clamped to the speed limit
	assign ang_sh      = prod_q[65:16];
	assign spd_lim     = {19'd0, spdlim_q};
	assign spd_lim_neg = -spd_lim;

	assign tmp_ext = {4'd0, tmp_q};
	assign acc_sh  = acc_q[63:16];
	assign gain_sh = prod_q[65:16];

	// output clamp never exceeds the supply
	assign v_lim   = (vlimit_q < supply_q) ? vlimit_q : supply_q;
	assign v_lim50 = {28'd0, v_lim};

	// slew limit: move at most one step from the previous voltage
	assign d_abs  = d_q[33] ? 34'(-d_q) : 34'(d_q);
	assign prev34 = 34'(prev_v_q);
	assign step34 = {3'd0, step_q};

	always_comb begin
		if (over_q) begin
			v_new = d_q[33] ? (prev34 - step34) : (prev34 + step34);
		end else begin
			v_new = v_q[33:0];
		end
	end

	assign v_sat = sat32(50'(v_new));

	// pwm scale works on the magnitude, the sign comes from the voltage
	assign prod_neg    = -prod_q;
	assign pwm_mag     = prod_q[PW-1] ? prod_neg[DW-1:0] : prod_q[DW-1:0];
	assign supply_zero = (supply_q == '0);

	// multiplier operand select
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_ANG_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = {ang_err[31], ang_err};
				mul_req.b  = {2'd0, again_q};
			end
			ST_ERR: begin
				mul_req.en = 1'b1;
				mul_req.a  = {14'd0, ts_q};
				mul_req.b  = {2'd0, iit_q};
			end
			ST_ACC_A: begin
				mul_req.en = 1'b1;
				mul_req.a  = tmp_ext + ONE_Q16;
				mul_req.b  = {err_q[31], err_q};
			end
			ST_ACC_B: begin
				mul_req.en = 1'b1;
				mul_req.a  = tmp_ext - ONE_Q16;
				mul_req.b  = {prev_e_q[31], prev_e_q};
			end
			ST_GAIN_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = {inner_q[31], inner_q};
				mul_req.b  = {2'd0, vgain_q};
			end
			ST_V_SUM: begin
				mul_req.en = 1'b1;
				mul_req.a  = {14'd0, ts_q};
				mul_req.b  = {2'd0, ramp_q};
			end
			ST_PWM_MUL: begin
				mul_req.en = 1'b1;
				mul_req.a  = {{(MW - FS_W){1'b0}}, FS};
				mul_req.b  = {volt_q[31], volt_q};
			end
			default: begin
				mul_req.en = 1'b0;
			end
		endcase
	end

	// divider operand select
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_TMP_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q[DW-1:0];
				div_req.divisor  = cmpc_pkg::TMP_DIVISOR;
			end
			ST_V_CLAMP: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q[DW-1:0];
				div_req.divisor  = cmpc_pkg::STEP_DIVISOR;
			end
			ST_PWM_DIV: begin
				div_req.start    = !supply_zero;
				div_req.dividend = pwm_mag;
				div_req.divisor  = supply_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cmpc_pkg::RST_CONTROL_MODE;
			supply_q <= cmpc_pkg::RST_SUPPLY_VOLTAGE;
			vgain_q  <= cmpc_pkg::RST_VELOCITY_GAIN;
			iit_q    <= cmpc_pkg::RST_INV_INT_TIME;
			vlimit_q <= cmpc_pkg::RST_VOLTAGE_LIMIT;
			ramp_q   <= cmpc_pkg::RST_VOLTAGE_RAMP;
			again_q  <= cmpc_pkg::RST_ANGLE_GAIN;
			spdlim_q <= cmpc_pkg::RST_SPEED_LIMIT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cmpc_pkg::REG_CONTROL_MODE:   mode_q   <= cfg_data[1:0];
				cmpc_pkg::REG_SUPPLY_VOLTAGE: supply_q <= cfg_data[VW-1:0];
				cmpc_pkg::REG_VELOCITY_GAIN:  vgain_q  <= cfg_data[GW-1:0];
				cmpc_pkg::REG_INV_INT_TIME:   iit_q    <= cfg_data[GW-1:0];
				cmpc_pkg::REG_VOLTAGE_LIMIT:  vlimit_q <= cfg_data[VW-1:0];
				cmpc_pkg::REG_VOLTAGE_RAMP:   ramp_q   <= cfg_data[GW-1:0];
				cmpc_pkg::REG_ANGLE_GAIN:     again_q  <= cfg_data[GW-1:0];
				cmpc_pkg::REG_SPEED_LIMIT:    spdlim_q <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// pi history, updated once per pi tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_v_q <= '0;
			prev_e_q <= '0;
		end else if (state_q == ST_COMMIT) begin
			prev_v_q <= v_sat;
			prev_e_q <= err_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					tgt_q  <= target;
					ang_q  <= measured_angle;
					vel_q  <= measured_velocity;
					ts_q   <= ts_in;
					volt_q <= target;
				end
			end
			ST_ANG_CLAMP: begin
				// the clamped velocity setpoint replaces the target
				priority if (ang_sh > spd_lim) begin
					tgt_q <= spd_lim[31:0];
				end else if (ang_sh < spd_lim_neg) begin
					tgt_q <= spd_lim_neg[31:0];
				end else begin
					tgt_q <= ang_sh[31:0];
				end
			end
			ST_ERR: begin
				err_q <= sat32(50'(err_diff));
			end
			ST_TMP_WAIT: begin
				if (div_rsp.done) begin
					tmp_q <= div_rsp.quotient[cmpc_pkg::TMP_W-1:0];
				end
			end
			ST_ACC_B: begin
				acc_q <= prod_q[63:0];
			end
			ST_ACC_SUM: begin
				acc_q <= acc_q + prod_q[63:0];
			end
			ST_INNER: begin
				inner_q <= sat32(50'(acc_sh));
			end
			ST_V_SUM: begin
				v_q <= gain_sh + 50'(prev_v_q);
			end
			ST_V_CLAMP: begin
				priority if (v_q > v_lim50) begin
					v_q <= v_lim50;
				end else if (v_q < -v_lim50) begin
					v_q <= -v_lim50;
				end else begin
					v_q <= v_q;
				end
			end
			ST_DIFF: begin
				d_q <= v_q[33:0] - prev34;
			end
			ST_STEP_WAIT: begin
				if (div_rsp.done) begin
					step_q <= div_rsp.quotient[cmpc_pkg::STEP_W-1:0];
				end
			end
			ST_CMP: begin
				over_q <= (d_abs > 34'(step34));
			end
			ST_COMMIT: begin
				volt_q <= v_sat;
			end
			ST_PWM_DIV: begin
				// zero supply: full scale in the direction of the voltage
				if (supply_zero) begin
					qmag_q <= (volt_q != '0) ? FS : '0;
				end
			end
			ST_PWM_WAIT: begin
				if (div_rsp.done) begin
					qmag_q <= (div_rsp.quotient >= DW'(FS)) ? FS
					                                        : div_rsp.quotient[FS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
			drive_voltage_q <= '0;
			pwm_duty_q      <= '0;
			direction_q     <= 1'b0;
		end else begin
			// in the output state the register is reloaded below instead
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (mode_q)
							cmpc_pkg::MODE_ANGLE:    state_q <= ST_ANG_MUL;
							cmpc_pkg::MODE_VELOCITY: state_q <= ST_ERR;
							default:                 state_q <= ST_PWM_MUL;
						endcase
					end
				end
				ST_ANG_MUL:   state_q <= ST_ANG_CLAMP;
				ST_ANG_CLAMP: state_q <= ST_ERR;
				ST_ERR:       state_q <= ST_TMP_DIV;
				ST_TMP_DIV:   state_q <= ST_TMP_WAIT;
				ST_TMP_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_ACC_A;
					end
				end
				ST_ACC_A:     state_q <= ST_ACC_B;
				ST_ACC_B:     state_q <= ST_ACC_SUM;
				ST_ACC_SUM:   state_q <= ST_INNER;
				ST_INNER:     state_q <= ST_GAIN_MUL;
				ST_GAIN_MUL:  state_q <= ST_V_SUM;
				ST_V_SUM:     state_q <= ST_V_CLAMP;
				ST_V_CLAMP:   state_q <= ST_DIFF;
				ST_DIFF:      state_q <= ST_STEP_WAIT;
				ST_STEP_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP:       state_q <= ST_COMMIT;
				ST_COMMIT:    state_q <= ST_PWM_MUL;
				ST_PWM_MUL:   state_q <= ST_PWM_DIV;
				ST_PWM_DIV: begin
					state_q <= supply_zero ? ST_OUT : ST_PWM_WAIT;
				end
				ST_PWM_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// wait here while the previous result is still unclaimed
					if (!out_valid_q || out_ready) begin
						out_valid_q     <= 1'b1;
						drive_voltage_q <= volt_q;
						pwm_duty_q      <= (qmag_q > FS_W'(cmpc_pkg::PWM_DUTY_MAX))
						                   ? cmpc_pkg::PWM_DUTY_MAX : qmag_q[7:0];
						direction_q     <= !volt_q[31] && (qmag_q != '0);
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign drive_voltage = drive_voltage_q;
	assign pwm_duty      = pwm_duty_q;
	assign direction     = direction_q;

	// an accepted tick always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted transfer did not start a tick");

	// a quotient only arrives while the sequencer waits for one
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_TMP_WAIT || state_q == ST_STEP_WAIT ||
		                  state_q == ST_PWM_WAIT))
		else $error("divider finished outside a wait state");

	// a positive direction always comes with a nonzero duty
	a_dir_has_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direction |-> pwm_duty != '0)
		else $error("direction set with zero pwm duty");

	// the pi history only moves on a pi tick
	a_history_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(prev_e_q) |-> $past(state_q) == ST_COMMIT)
		else $error("pi history changed outside commit");

endmodule

// ----- src/cmpc_multiplier.sv -----
// shared signed multiplier with registered product
module cmpc_multiplier (
	input  logic                                   clk,
	input  cmpc_pkg::mul_req_t                     req,
	output logic signed [cmpc_pkg::PROD_W-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

endmodule

// ----- src/cmpc_divider.sv -----
// iterative unsigned restoring divider, a few quotient bits per cycle
module cmpc_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  cmpc_pkg::div_req_t req,
	output cmpc_pkg::div_rsp_t rsp
);

	localparam int DVD_W = cmpc_pkg::DIV_DVD_W;
	localparam int DVS_W = cmpc_pkg::DIV_DVS_W;
	localparam int BPC   = cmpc_pkg::DIV_BITS_PER_CYCLE;
	localparam int STEPS = DVD_W / BPC;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W-1:0] rem_n;
	logic [DVD_W-1:0] quo_n;
	logic [DVS_W:0]   trial;

	// dividend bits shift out of the top of quo while quotient bits enter below
	always_comb begin
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < BPC; i++) begin
			trial = {rem_n, quo_n[DVD_W-1]};
			quo_n = {quo_n[DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial    = trial - {1'b0, dvs_q};
				quo_n[0] = 1'b1;
			end
			rem_n = trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
